>>> rtl/bpg_pkg.sv
// bpg_pkg: shared types and constants for the bitmap byte to gray converter
// no dependencies; imported by bpg_front, bpg_back and bmp_pixel_bytes_to_gray

package bpg_pkg;

	// pixel format codes
	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_BGR  = 2'd1;
	localparam logic [1:0] FMT_BGRA = 2'd2;

	// register indexes (word address bits [3:2])
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	// q16 luma weights
	localparam logic [15:0] WEIGHT_R = 16'd19595;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_B = 16'd7471;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [1:0]  pixel_format;
	} cfg_t;

	// one pixel handed from front to back
	typedef struct packed {
		logic       passthrough;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       row_end;
		logic       image_end;
	} cmd_t;

	typedef struct packed {
		logic [7:0] gray_value;
		logic       row_end;
		logic       image_end;
	} res_t;

endpackage

>>> rtl/bpg_fifo.sv
// bpg_fifo: small register queue with full/empty flags
// no package dependency; DEPTH must be a power of two, at least 2

module bpg_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

>>> rtl/bpg_front.sv
// bpg_front: byte position tracking, pad dropping and pixel assembly
// depends on bpg_pkg; pushes one cmd_t per completed pixel

module bpg_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bpg_pkg::cfg_t cfg,
	input  logic          in_push,
	input  logic [7:0]    in_byte,
	output logic          in_full,
	output logic          cmd_push,
	output bpg_pkg::cmd_t cmd_data,
	input  logic          cmd_full
);
	import bpg_pkg::*;

	localparam int LEN_W = $clog2(4*MAX_WIDTH + 1);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [LEN_W-1:0] pos_q;
	logic [1:0]       ch_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       blue_q;
	logic [7:0]       green_q;
	logic [7:0]       red_q;

	logic [31:0]      w_ext;
	logic [31:0]      h_ext;
	logic [31:0]      w_eff;
	logic [31:0]      h_eff;
	logic [LEN_W-1:0] w_len;
	logic [LEN_W-1:0] data_len;
	logic [LEN_W:0]   pad_sum;
	logic [LEN_W:0]   padded;
	logic [LEN_W:0]   pos_inc;
	logic [ROW_W-1:0] last_row;
	logic [1:0]       last_ch;
	logic             gray_mode;
	logic             accept;
	logic             in_data;
	logic             row_done;
	logic             row_last;
	logic             pix_done;
	logic [7:0]       blue_n;
	logic [7:0]       green_n;
	logic [7:0]       red_n;

	always_comb begin
		w_ext = 32'(cfg.image_width);
		h_ext = 32'(cfg.image_height);
		if (w_ext == 32'd0) w_eff = 32'd1;
		else if (w_ext > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
		else w_eff = w_ext;
		if (h_ext == 32'd0) h_eff = 32'd1;
		else if (h_ext > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
		else h_eff = h_ext;
		w_len    = LEN_W'(w_eff);
		last_row = ROW_W'(h_eff - 32'd1);

		unique case (cfg.pixel_format)
			FMT_GRAY: begin
				data_len = w_len;
				last_ch  = 2'd0;
			end
			FMT_BGR: begin
				data_len = w_len + (w_len << 1);
				last_ch  = 2'd2;
			end
			default: begin
				// bgra, and the unused code acts as bgra
				data_len = w_len << 2;
				last_ch  = 2'd3;
			end
		endcase
		gray_mode = (cfg.pixel_format == FMT_GRAY);

		pad_sum  = {1'b0, data_len} + (LEN_W+1)'(3);
		padded   = {pad_sum[LEN_W:2], 2'b00};
		pos_inc  = {1'b0, pos_q} + 1'b1;
		in_data  = ({1'b0, pos_q} < {1'b0, data_len});
		row_done = (pos_inc >= padded);
		row_last = (row_q >= last_row);
		pix_done = in_data && (gray_mode || (ch_q >= last_ch));

		blue_n  = (ch_q == 2'd0) ? in_byte : blue_q;
		green_n = (ch_q == 2'd1) ? in_byte : green_q;
		red_n   = (ch_q == 2'd2) ? in_byte : red_q;
	end

	assign in_full  = cmd_full;
	assign accept   = in_push & ~cmd_full;
	assign cmd_push = accept & pix_done;

	always_comb begin
		cmd_data.passthrough = gray_mode;
		cmd_data.blue        = gray_mode ? in_byte : blue_n;
		cmd_data.green       = green_n;
		cmd_data.red         = red_n;
		cmd_data.row_end     = (pos_inc >= {1'b0, data_len});
		cmd_data.image_end   = cmd_data.row_end && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ch_q    <= '0;
			row_q   <= '0;
			blue_q  <= '0;
			green_q <= '0;
			red_q   <= '0;
		end else if (accept) begin
			if (in_data && !gray_mode) begin
				blue_q  <= blue_n;
				green_q <= green_n;
				red_q   <= red_n;
			end
			if (row_done) begin
				pos_q <= '0;
				ch_q  <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				pos_q <= pos_inc[LEN_W-1:0];
				if (in_data) ch_q <= pix_done ? 2'd0 : ch_q + 2'd1;
			end
		end
	end

	// image end only ever rides on the last pixel of a row
	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd_data.image_end |-> cmd_data.row_end)
		else $error("image end without row end");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_done |=> (pos_q == '0) && (ch_q == 2'd0))
		else $error("row position not cleared after row end");

endmodule

>>> rtl/bpg_back.sv
// bpg_back: luma weighting of queued pixels and the result queue
// depends on bpg_pkg and bpg_fifo

module bpg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bpg_pkg::cmd_t cmd_data,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output bpg_pkg::res_t res_data,
	output logic          res_empty,
	input  logic          res_pop
);
	import bpg_pkg::*;

	localparam int OCC_W = $clog2(RES_DEPTH + 1);

	logic [OCC_W-1:0] occ_q;
	logic             valid_s1;
	logic             pass_s1;
	logic [7:0]       byte_s1;
	logic [23:0]      prod_r_s1;
	logic [23:0]      prod_g_s1;
	logic [23:0]      prod_b_s1;
	logic             row_end_s1;
	logic             image_end_s1;
	logic [23:0]      luma_sum;
	res_t             res_in;
	logic             res_full;
	logic             res_taken;

	// occupancy counts the pixel in flight plus queued results
	assign cmd_pop   = ~cmd_empty && (occ_q < OCC_W'(RES_DEPTH));
	assign res_taken = res_pop & ~res_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
			if (cmd_pop && !res_taken) occ_q <= occ_q + 1'b1;
			else if (res_taken && !cmd_pop) occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pass_s1      <= cmd_data.passthrough;
			byte_s1      <= cmd_data.blue;
			prod_r_s1    <= 24'(WEIGHT_R) * 24'(cmd_data.red);
			prod_g_s1    <= 24'(WEIGHT_G) * 24'(cmd_data.green);
			prod_b_s1    <= 24'(WEIGHT_B) * 24'(cmd_data.blue);
			row_end_s1   <= cmd_data.row_end;
			image_end_s1 <= cmd_data.image_end;
		end
	end

	// weights sum to 65536, so the sum of products fits 24 bits
	assign luma_sum          = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign res_in.gray_value = pass_s1 ? byte_s1 : luma_sum[23:16];
	assign res_in.row_end    = row_end_s1;
	assign res_in.image_end  = image_end_s1;

	bpg_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.din    (res_in),
		.full   (res_full),
		.pop    (res_pop),
		.dout   (res_data),
		.empty  (res_empty)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(RES_DEPTH))
		else $error("result occupancy above queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !res_full)
		else $error("result queue written while full");

	a_empty_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> res_empty && !valid_s1)
		else $error("result present with zero occupancy");

endmodule

>>> rtl/bmp_pixel_bytes_to_gray.sv
// bmp_pixel_bytes_to_gray: padded bitmap pixel bytes in, gray pixels out
// depends on bpg_pkg, bpg_fifo, bpg_front, bpg_back
//
// channel   direction  handshake                 payload
// bytes     in         push / full               raw_byte[7:0]
// pixels    out        empty / pop               gray_value[7:0], row_end, image_end
// config    in         apb psel/penable/pready   paddr[3:0], pwdata/prdata[31:0]
//
// one byte beat per cycle sustained while full is low; the front decides pad/pixel
// in the cycle it takes the byte, and a completed pixel then passes through the
// command queue, the product register and the result queue to the result side
// arst_n clears counters and queues and sets the config (width 1, height 1, 8-bit format)
// full rises only when the four-entry command queue fills; the back stalls on its
// own when the four-entry result queue is held by pop low

module bmp_pixel_bytes_to_gray #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  raw_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  gray_value,
	output logic        row_end,
	output logic        image_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bpg_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_write;
	logic [1:0] reg_idx;
	logic       cmd_push;
	cmd_t       cmd_in;
	logic       cmd_full;
	logic       cmd_pop;
	cmd_t       cmd_out;
	logic       cmd_empty;
	res_t       res;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'd1;
			cfg_q.image_height <= 13'd1;
			cfg_q.pixel_format <= FMT_GRAY;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.image_width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.image_height <= pwdata[12:0];
				REG_FORMAT: cfg_q.pixel_format <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = {19'd0, cfg_q.image_width};
			REG_HEIGHT: prdata = {19'd0, cfg_q.image_height};
			REG_FORMAT: prdata = {30'd0, cfg_q.pixel_format};
			default:    prdata = '0;
		endcase
	end

	bpg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_push  (push),
		.in_byte  (raw_byte),
		.in_full  (full),
		.cmd_push (cmd_push),
		.cmd_data (cmd_in),
		.cmd_full (cmd_full)
	);

	bpg_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	bpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_data  (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign gray_value = res.gray_value;
	assign row_end    = res.row_end;
	assign image_end  = res.image_end;

endmodule
